>>> rtl/core/iso_timestamp_to_epoch_top_defines.svh
// Assertion macros shared by the timestamp converter modules.
// Each expects signals named clock and reset in the module that uses it.
`ifndef ISO_TIMESTAMP_TO_EPOCH_TOP_DEFINES_SVH
`define ISO_TIMESTAMP_TO_EPOCH_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITE_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ite_pkg.sv
package ite_pkg;

   localparam int MAX_CHARS_DEF = 20;
   localparam int CNT_W         = 5;
   localparam int YEAR_W        = 14;
   localparam int FIELD_W       = 7;
   localparam int SECONDS_LEN   = 17;
   localparam int YEAR_BASE     = 1900;
   localparam int YEAR_SPAN     = 200;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_Z     = 8'h5A;

   typedef enum logic [2:0] {
      FIELD_YEAR,
      FIELD_MONTH,
      FIELD_DAY,
      FIELD_HOUR,
      FIELD_MINUTE,
      FIELD_SECOND
   } field_type;

   // One scanned timestamp handed from the scanner to the calculator.
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic               fmt_err;
   } stamp_type;

   // Separator that closes the given field; none after seconds.
   function automatic logic [7:0] field_sep(input field_type f);
      logic [7:0] s;
      case (f)
         FIELD_YEAR:   s = CHAR_DASH;
         FIELD_MONTH:  s = CHAR_DASH;
         FIELD_DAY:    s = CHAR_T;
         FIELD_HOUR:   s = CHAR_COLON;
         FIELD_MINUTE: s = CHAR_COLON;
         default:      s = CHAR_NUL;
      endcase
      return s;
   endfunction

   // Days in the non-leap year before the first of the month.
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

>>> rtl/core/ite_front.sv
module ite_front import ite_pkg::*; #(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic [7:0] req_char_code,
   input  logic      req_last_char,
   input  logic      q_full,
   output logic      q_push,
   output stamp_type q_data
);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   field_type          field_ff, field_in;
   logic [2:0]         dcnt_ff, dcnt_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in;
   logic [FIELD_W-1:0] day_ff, day_in;
   logic [FIELD_W-1:0] hour_ff, hour_in;
   logic [FIELD_W-1:0] minute_ff, minute_in;
   logic [FIELD_W-1:0] second_ff, second_in;
   logic               err_ff, err_in;
   logic               stop_ff, stop_in;
   logic               accept;
   logic               is_digit;
   logic [3:0]         digit;
   logic [2:0]         cap;
   field_type          need_field;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_digit  = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign digit     = req_char_code[3:0];
   assign cap       = (field_ff == FIELD_YEAR) ? 3'd4 : 3'd2;

   always_comb begin
      cnt_in     = cnt_ff;
      field_in   = field_ff;
      dcnt_in    = dcnt_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      err_in     = err_ff;
      stop_in    = stop_ff;
      q_push     = 1'b0;
      need_field = FIELD_MINUTE;

      if (accept && !stop_ff && (cnt_ff < CNT_W'(MAX_CHARS))) begin
         if ((req_char_code == CHAR_Z) || (req_char_code == CHAR_NUL)) begin
            stop_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (is_digit) begin
               if (dcnt_ff >= cap) begin
                  err_in = 1'b1;
               end else begin
                  dcnt_in = dcnt_ff + 3'd1;
                  case (field_ff)
                     FIELD_YEAR:   year_in   = YEAR_W'(year_ff * YEAR_W'(10)) + YEAR_W'(digit);
                     FIELD_MONTH:  month_in  = FIELD_W'(month_ff * FIELD_W'(10)) + FIELD_W'(digit);
                     FIELD_DAY:    day_in    = FIELD_W'(day_ff * FIELD_W'(10)) + FIELD_W'(digit);
                     FIELD_HOUR:   hour_in   = FIELD_W'(hour_ff * FIELD_W'(10)) + FIELD_W'(digit);
                     FIELD_MINUTE: minute_in = FIELD_W'(minute_ff * FIELD_W'(10)) + FIELD_W'(digit);
                     default:      second_in = FIELD_W'(second_ff * FIELD_W'(10)) + FIELD_W'(digit);
                  endcase
               end
            end else if ((field_ff != FIELD_SECOND) && (req_char_code == field_sep(field_ff))) begin
               if (dcnt_ff == 3'd0) begin
                  err_in = 1'b1;
               end
               field_in = field_type'(field_ff + 3'd1);
               dcnt_in  = 3'd0;
            end else begin
               err_in = 1'b1;
            end
         end
      end

      // Pack the record from the state after this word; a last word restarts the scan.
      if (cnt_in >= CNT_W'(SECONDS_LEN)) begin
         need_field = FIELD_SECOND;
      end
      q_data.year    = year_in;
      q_data.month   = month_in;
      q_data.day     = day_in;
      q_data.hour    = hour_in;
      q_data.minute  = minute_in;
      q_data.second  = second_in;
      q_data.fmt_err = err_in || (field_in != need_field) || (dcnt_in == 3'd0);

      if (accept && req_last_char) begin
         q_push    = 1'b1;
         cnt_in    = '0;
         field_in  = FIELD_YEAR;
         dcnt_in   = '0;
         year_in   = '0;
         month_in  = '0;
         day_in    = '0;
         hour_in   = '0;
         minute_in = '0;
         second_in = '0;
         err_in    = 1'b0;
         stop_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         field_ff  <= FIELD_YEAR;
         dcnt_ff   <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         err_ff    <= 1'b0;
         stop_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         field_ff  <= field_in;
         dcnt_ff   <= dcnt_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         err_ff    <= err_in;
         stop_ff   <= stop_in;
      end
   end

endmodule

>>> rtl/core/ite_queue.sv
`include "iso_timestamp_to_epoch_top_defines.svh"

module ite_queue import ite_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  stamp_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output stamp_type head_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   stamp_type       slot_ff [QUEUE_DEPTH];
   stamp_type       slot_in [QUEUE_DEPTH];
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   wr_idx;

   assign full       = (cnt_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[0];
   assign wr_idx     = pop ? (cnt_ff - CW'(1)) : cnt_ff;

   // Shift toward the head on pop; write the new word behind the last one.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i + 1 < QUEUE_DEPTH)) begin
            slot_in[i] = slot_ff[(i + 1) % QUEUE_DEPTH];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (push && (wr_idx == CW'(i))) begin
            slot_in[i] = push_data;
         end
      end
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `ITE_ASSERT_IMPLY(a_no_overflow, push, !full, "queue written while full")
   `ITE_ASSERT_IMPLY(a_no_underflow, pop, head_valid, "queue read while empty")
   `ITE_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_ff <= CW'(QUEUE_DEPTH), "queue count out of range")

endmodule

>>> rtl/core/ite_back.sv
`include "iso_timestamp_to_epoch_top_defines.svh"

module ite_back import ite_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  stamp_type   q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_epoch_seconds,
   output logic        rsp_parse_error
);

   // Stage A: checks, day count and time of day.
   logic               a_valid_ff, a_valid_in;
   logic               a_bad_ff;
   logic signed [17:0] a_days_ff;
   logic [16:0]        a_secs_ff;
   // Output register.
   logic               o_valid_ff, o_valid_in;
   logic [31:0]        o_epoch_ff;
   logic               o_err_ff;

   logic               out_ready;
   logic               a_ready;
   logic [YEAR_W-1:0]  t_full;
   logic [7:0]         t;
   logic               range_bad;
   logic               leap;
   logic [8:0]         yday;
   logic signed [8:0]  ts;
   logic signed [8:0]  x;
   logic signed [8:0]  xn;
   logic signed [8:0]  q;
   logic signed [17:0] yr_days;
   logic signed [17:0] days;
   logic [16:0]        secs;
   logic signed [35:0] prod;
   logic [31:0]        total;

   assign out_ready = !o_valid_ff || !rsp_stall;
   assign a_ready   = !a_valid_ff || out_ready;
   assign q_pop     = q_valid && a_ready;
   assign a_valid_in = a_ready ? q_valid : a_valid_ff;
   assign o_valid_in = out_ready ? a_valid_ff : o_valid_ff;

   always_comb begin
      t_full    = q_data.year - YEAR_W'(YEAR_BASE);
      t         = t_full[7:0];
      range_bad = (q_data.year < YEAR_W'(YEAR_BASE))
               || (q_data.year > YEAR_W'(YEAR_BASE + YEAR_SPAN))
               || (q_data.month == '0) || (q_data.month > FIELD_W'(12))
               || (q_data.day == '0) || (q_data.day > FIELD_W'(31))
               || (q_data.hour > FIELD_W'(23))
               || (q_data.minute > FIELD_W'(59))
               || (q_data.second > FIELD_W'(59));
      // Within 1900..2100 the only century years are 1900, 2000 and 2100.
      leap = (t[1:0] == 2'd0) && (t != 8'd0) && (t != 8'(YEAR_SPAN));
      yday = days_before_month(q_data.month[3:0])
           + 9'((q_data.month > FIELD_W'(2)) && leap)
           + 9'(q_data.day) - 9'd1;
      ts = $signed({1'b0, t});
      x  = ts - 9'sd69;
      xn = -x;
      // Leap days since the epoch year, division truncating toward zero.
      q  = x[8] ? -(xn >>> 2) : (x >>> 2);
      yr_days = 18'(ts - 9'sd70) * 18'sd365;
      days    = yr_days + 18'(q) + $signed({9'b0, yday});
      secs    = 17'(q_data.second) + 17'(q_data.minute) * 17'd60
              + 17'(q_data.hour) * 17'd3600;
   end

   always_comb begin
      prod  = 36'(a_days_ff) * 36'sd86400;
      total = prod[31:0] + 32'(a_secs_ff);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_bad_ff  <= q_data.fmt_err || range_bad;
         a_days_ff <= days;
         a_secs_ff <= secs;
      end
      if (a_valid_ff && out_ready) begin
         o_epoch_ff <= a_bad_ff ? 32'd0 : total;
         o_err_ff   <= a_bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_epoch_seconds = o_epoch_ff;
   assign rsp_parse_error   = o_err_ff;

   `ITE_ASSERT_IMPLY(a_err_zero, o_valid_ff && o_err_ff, o_epoch_ff == 32'd0, "error word with nonzero epoch")
   `ITE_ASSERT_NEXT(a_hold_stage, a_valid_ff && !out_ready, a_valid_ff, "stage A dropped while output stalled")

endmodule

>>> rtl/core/iso_timestamp_to_epoch_top.sv
// Channel  | Ports                                      | Direction
// ---------+--------------------------------------------+----------
// req      | req_valid req_stall req_char_code          | in
//          | req_last_char                              |
// rsp      | rsp_valid rsp_stall rsp_epoch_seconds      | out
//          | rsp_parse_error                            |
//
// One character word is taken every cycle while the scanner to calculator
// queue has room; req_stall rises only when that two-entry queue is full.
// The result for the word that carries last_char passes the queue slot, the
// check stage and the multiply-add into the output register.
// Synchronous active-high reset clears the scan state, the queue and all
// valid flags. A stalled result holds the calculator and, once the queue
// fills, the scanner; neither side drops or repeats a word.
module iso_timestamp_to_epoch_top import ite_pkg::*; #(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_epoch_seconds,
   output logic        rsp_parse_error
);

   logic      q_full;
   logic      q_push;
   stamp_type q_wdata;
   logic      q_pop;
   logic      q_valid;
   stamp_type q_head;

   // Scanner: accumulate fields per character, push one record per string.
   ite_front #(
      .MAX_CHARS (MAX_CHARS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wdata)
   );

   // Decouple the scanner from the calculator.
   ite_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // Calculator: range checks, day count, then seconds since the epoch.
   ite_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_parse_error   (rsp_parse_error)
   );

endmodule

>>> bench/iso_timestamp_to_epoch_top_tb.sv
`timescale 1ns / 100ps

module iso_timestamp_to_epoch_top_tb;
   import ite_pkg::*;

   // One character word on the request channel.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_word_type;

   // One epoch result word as the response channel should carry it.
   typedef struct packed {
      logic [31:0] seconds;
      logic        error;
   } epoch_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_epoch_seconds;
   logic        rsp_parse_error;

   iso_timestamp_to_epoch_top #(.MAX_CHARS(MAX_CHARS_DEF)) dut (.*);

   // Character words waiting to be offered, and epoch words still owed by the block.
   char_word_type  char_pending[$];
   epoch_word_type epoch_expected[$];
   logic [7:0]     stamp_text[$];

   int chars_total     = 0;
   int chars_accepted  = 0;
   int mismatch_count  = 0;
   int send_gap        = 0;
   int recv_gap        = 0;
   bit send_idling     = 1'b1;
   bit recv_idling     = 1'b1;
   bit wind_down       = 1'b0;
   bit hold_off        = 1'b0;

   // Scanner copy kept by the bench, at the block's own widths.
   logic [CNT_W-1:0]   scan_count;
   field_type          scan_field;
   logic [2:0]         scan_digits;
   logic [YEAR_W-1:0]  scan_year;
   logic [FIELD_W-1:0] scan_month;
   logic [FIELD_W-1:0] scan_day;
   logic [FIELD_W-1:0] scan_hour;
   logic [FIELD_W-1:0] scan_minute;
   logic [FIELD_W-1:0] scan_second;
   logic               scan_error;
   logic               scan_stopped;

   int days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   function automatic void clear_scan();
      scan_count   = '0;
      scan_field   = FIELD_YEAR;
      scan_digits  = '0;
      scan_year    = '0;
      scan_month   = '0;
      scan_day     = '0;
      scan_hour    = '0;
      scan_minute  = '0;
      scan_second  = '0;
      scan_error   = 1'b0;
      scan_stopped = 1'b0;
   endfunction

   // Advance the scanner copy by one character.
   function automatic void scan_character(input logic [7:0] code);
      logic [7:0] sep;
      logic [3:0] digit;
      if (scan_stopped || scan_count >= MAX_CHARS_DEF) return;
      // A 'Z' or NUL ends the scan without being counted.
      if (code == CHAR_Z || code == CHAR_NUL) begin
         scan_stopped = 1'b1;
         return;
      end
      scan_count = scan_count + 1'b1;
      case (scan_field)
         FIELD_YEAR, FIELD_MONTH: sep = CHAR_DASH;
         FIELD_DAY:               sep = CHAR_T;
         default:                 sep = CHAR_COLON;
      endcase
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         digit = 4'(code - CHAR_ZERO);
         // Drop the digit and flag a fifth year digit or a third one elsewhere.
         if (scan_digits >= ((scan_field == FIELD_YEAR) ? 3'd4 : 3'd2)) begin
            scan_error = 1'b1;
         end else begin
            scan_digits = scan_digits + 1'b1;
            case (scan_field)
               FIELD_YEAR:   scan_year   = YEAR_W'(scan_year * 10 + digit);
               FIELD_MONTH:  scan_month  = FIELD_W'(scan_month * 10 + digit);
               FIELD_DAY:    scan_day    = FIELD_W'(scan_day * 10 + digit);
               FIELD_HOUR:   scan_hour   = FIELD_W'(scan_hour * 10 + digit);
               FIELD_MINUTE: scan_minute = FIELD_W'(scan_minute * 10 + digit);
               default:      scan_second = FIELD_W'(scan_second * 10 + digit);
            endcase
         end
      end else if (scan_field != FIELD_SECOND && code == sep) begin
         if (scan_digits == 0) scan_error = 1'b1;
         scan_field  = field_type'(scan_field + 1);
         scan_digits = '0;
      end else begin
         scan_error = 1'b1;
      end
   endfunction

   // Close the string: range checks, then seconds since 1970 modulo 2^32.
   function automatic epoch_word_type close_timestamp();
      epoch_word_type result;
      field_type      need;
      logic           bad;
      longint         t, yday, total, sec, mins, hrs, dd;
      need = (scan_count >= SECONDS_LEN) ? FIELD_SECOND : FIELD_MINUTE;
      bad = scan_error || scan_field != need || scan_digits == 0
         || scan_year < YEAR_BASE || scan_year > YEAR_BASE + YEAR_SPAN
         || scan_month < 1 || scan_month > 12 || scan_day < 1 || scan_day > 31
         || scan_hour > 23 || scan_minute > 59 || scan_second > 59;
      if (bad) begin
         result.seconds = '0;
         result.error   = 1'b1;
      end else begin
         t    = scan_year;
         t    = t - YEAR_BASE;
         sec  = scan_second;
         mins = scan_minute;
         hrs  = scan_hour;
         dd   = scan_day;
         yday = days_before[scan_month - 1];
         if (scan_month > 2 && (((scan_year % 4 == 0) && (scan_year % 100 != 0))
             || (scan_year % 400 == 0)))
            yday = yday + 1;
         yday  = yday + dd - 1;
         total = sec + mins * 60 + hrs * 3600 + yday * 86400
               + (t - 70) * 31536000
               + ((t - 69) / 4) * 86400
               - ((t - 1) / 100) * 86400
               + ((t + 299) / 400) * 86400;
         result.seconds = total[31:0];
         result.error   = 1'b0;
      end
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------

   // Append ndigits decimal digits of value, leading zeros kept.
   function automatic void add_number(input int value, input int ndigits);
      int scale;
      scale = 1;
      for (int i = 1; i < ndigits; i++) scale = scale * 10;
      for (int i = 0; i < ndigits; i++) begin
         stamp_text.push_back(CHAR_ZERO + 8'((value / scale) % 10));
         scale = scale / 10;
      end
   endfunction

   // Field value: in range with a bias to the edges, or just outside them;
   // rough ones also take any value in the digit range.
   function automatic int pick_value(input int lo, input int hi, input int top,
                                     input bit rough);
      int roll;
      roll = $urandom_range(0, 15);
      if (!rough && roll > 5) roll = 7;
      case (roll)
         0, 1:    return lo;
         2, 3:    return hi;
         4:       return (lo > 0) ? lo - 1 : hi + 1;
         5:       return hi + 1;
         6:       return $urandom_range(0, top);
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic int pick_width(input int nominal, input bit rough);
      if (!rough) return nominal;
      case ($urandom_range(0, 9))
         0:       return nominal - 1;
         1:       return nominal + 1;
         2:       return 0;
         default: return nominal;
      endcase
   endfunction

   // A character that a timestamp is made of.
   function automatic logic [7:0] random_mark();
      case ($urandom_range(0, 4))
         0:       return CHAR_DASH;
         1:       return CHAR_COLON;
         2:       return CHAR_T;
         default: return CHAR_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   // Move the built text into the pending words, last flag on the final one.
   function automatic void queue_text();
      char_word_type w;
      foreach (stamp_text[i]) begin
         w.code = stamp_text[i];
         w.last = (i == stamp_text.size() - 1);
         char_pending.push_back(w);
      end
      stamp_text.delete();
   endfunction

   function automatic void add_timestamp();
      bit rough;
      bit with_seconds;
      int pos;
      rough        = ($urandom_range(0, 9) < 3);
      with_seconds = $urandom_range(0, 1);
      add_number(pick_value(YEAR_BASE, YEAR_BASE + YEAR_SPAN, 9999, rough),
                 pick_width(4, rough));
      stamp_text.push_back(CHAR_DASH);
      add_number(pick_value(1, 12, 99, rough), pick_width(2, rough));
      stamp_text.push_back(CHAR_DASH);
      add_number(pick_value(1, 31, 99, rough), pick_width(2, rough));
      stamp_text.push_back(CHAR_T);
      add_number(pick_value(0, 23, 99, rough), pick_width(2, rough));
      stamp_text.push_back(CHAR_COLON);
      add_number(pick_value(0, 59, 99, rough), pick_width(2, rough));
      if (with_seconds) begin
         stamp_text.push_back(CHAR_COLON);
         add_number(pick_value(0, 59, 99, rough), pick_width(2, rough));
      end
      // Break rough strings further: swap, drop, repeat or overrun the length.
      if (rough) begin
         pos = $urandom_range(0, stamp_text.size() - 1);
         case ($urandom_range(0, 5))
            0: stamp_text[pos] = 8'($urandom_range(0, 255));
            1: stamp_text[pos] = random_mark();
            2: stamp_text.delete(pos);
            3: stamp_text.insert(pos, stamp_text[pos]);
            4: repeat ($urandom_range(1, 6)) stamp_text.push_back(random_mark());
            default: ;
         endcase
      end
      case ($urandom_range(0, 7))
         0, 1: stamp_text.push_back(CHAR_Z);
         2: begin
            // Trailing junk after the terminator must be ignored.
            stamp_text.push_back(CHAR_Z);
            repeat ($urandom_range(1, 4)) stamp_text.push_back(8'($urandom_range(0, 255)));
         end
         3: stamp_text.push_back(CHAR_NUL);
         default: ;
      endcase
      queue_text();
   endfunction

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request driver: offer pending words, predict each accepted one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_chars
      char_word_type next_word;
      logic          take;
      if (reset) begin
         req_valid <= 1'b0;
         clear_scan();
      end else begin
         take = req_valid && !req_stall;
         // Feed the accepted word into the scanner copy; a last word owes a result.
         if (take) begin
            scan_character(req_char_code);
            if (req_last_char) begin
               epoch_expected.push_back(close_timestamp());
               clear_scan();
            end
            chars_accepted++;
         end
         // Hold a stalled word; otherwise idle out a gap or load the next word.
         if (!req_valid || take) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (char_pending.size() != 0) begin
               next_word = char_pending.pop_front();
               req_valid     <= 1'b1;
               req_char_code <= next_word.code;
               req_last_char <= next_word.last;
               if (send_idling && !wind_down && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
         // Toggle between idling and back-to-back stretches now and then.
         if ($urandom_range(0, 99) == 0) send_idling = !send_idling;
         // Stop all idling for the tail of the run.
         wind_down <= (char_pending.size() < 150);
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compare each accepted word, drive random stalls.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      epoch_word_type want;
      logic           stall_now;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (epoch_expected.size() == 0) begin
               $error("unexpected result word: epoch_seconds %0d parse_error %0b",
                      rsp_epoch_seconds, rsp_parse_error);
               mismatch_count++;
            end else begin
               want = epoch_expected.pop_front();
               if (rsp_epoch_seconds !== want.seconds) begin
                  $error("epoch_seconds: expected %0d, actual %0d",
                         want.seconds, rsp_epoch_seconds);
                  mismatch_count++;
               end
               if (rsp_parse_error !== want.error) begin
                  $error("parse_error: expected %0b, actual %0b",
                         want.error, rsp_parse_error);
                  mismatch_count++;
               end
            end
         end
         // Random stall bursts, independent of rsp_valid.
         if (recv_gap > 0) begin
            recv_gap--;
            stall_now = 1'b1;
         end else if (recv_idling && !wind_down && $urandom_range(0, 7) == 0) begin
            recv_gap  = $urandom_range(0, 10);
            stall_now = 1'b1;
         end else begin
            stall_now = 1'b0;
         end
         if ($urandom_range(0, 99) == 0) recv_idling = !recv_idling;
         rsp_stall <= stall_now || hold_off;
      end
   end

   // Hold the response side off long enough for the internal queue to fill
   // and push back on the request side while words keep coming.
   initial begin : long_hold
      while (chars_accepted < 400) @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Give up if the run hangs.
   initial begin : watchdog
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of test
   // ---------------------------------------------------------------------
   initial begin : run_test
      // Directed words: all-ones character, lone NUL, lone 'Z', a digit
      // followed by the wrong separator, then the lowest legal timestamp.
      stamp_text.push_back(8'hFF);
      queue_text();
      stamp_text.push_back(CHAR_NUL);
      queue_text();
      stamp_text.push_back(CHAR_Z);
      queue_text();
      stamp_text.push_back(CHAR_ZERO + 8'd7);
      stamp_text.push_back(CHAR_COLON);
      queue_text();
      add_number(YEAR_BASE, 4);
      stamp_text.push_back(CHAR_DASH);
      add_number(1, 2);
      stamp_text.push_back(CHAR_DASH);
      add_number(1, 2);
      stamp_text.push_back(CHAR_T);
      add_number(0, 2);
      stamp_text.push_back(CHAR_COLON);
      add_number(0, 2);
      queue_text();

      // Random part: mostly timestamps, now and then plain noise.
      while (char_pending.size() < 1150) begin
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 24)) begin
               if ($urandom_range(0, 3) == 0)
                  stamp_text.push_back(8'($urandom_range(0, 255)));
               else
                  stamp_text.push_back(random_mark());
            end
            queue_text();
         end else begin
            add_timestamp();
         end
      end
      chars_total = char_pending.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait until every word is taken and every result seen.
      while (chars_accepted < chars_total) @(posedge clock);
      while (epoch_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
